/* hdl/box_blend_smoother_macros.svh */
// Assertion helpers used by the checked datapath module
`ifndef BOX_BLEND_SMOOTHER_MACROS_SVH
`define BOX_BLEND_SMOOTHER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define BBS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bbs check failed");

// Next-cycle implication, disabled during reset
`define BBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bbs check failed");

`endif

/* hdl/bbs_pkg.sv */
package bbs_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_WEIGHT  = 2'd0;
   localparam logic [1:0] CSR_COLUMNS = 2'd1;
   localparam logic [1:0] CSR_ROWS    = 2'd2;

   localparam int WEIGHT_BITS  = 17;
   localparam int COLUMNS_BITS = 11;
   localparam int ROWS_BITS    = 16;
   localparam int CSR_BITS     = 17;
   localparam int NUM_CH       = 4;

   localparam logic [16:0] ONE_Q16 = 17'd65536;
   localparam logic [10:0] COLUMNS_RESET = 11'd1024;
   localparam logic [15:0] ROWS_RESET    = 16'd1024;

   // sequencer states
   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_SUM  = 6'b000010,
      ST_MUL  = 6'b000100,
      ST_ADD  = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_FIN  = 6'b100000
   } state_type;

   typedef struct packed {
      logic accept;
      logic sum_en;
      logic mul_en;
      logic add_en;
      logic div_en;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic interior;
      logic out_free;
   } ctrl_sts_type;

endpackage

/* hdl/box_blend_smoother.sv */
// 3x3 box blend smoother. Pixels of four signed Q4.12 channels come in raster
// order; every interior pixel leaves as old + weight*(3x3 mean - old), rounded
// and saturated, tagged with row and column, once its lower-right neighbour has
// arrived. Border pixels give no result. One request is in work at a time: an
// interior pixel steps through capture and line read, window sum, blend
// multiply, sum, divide by nine and load into the output register; a border
// pixel stops after the window sum. A new pixel is taken only once the previous
// one has left the blend datapath; the load step waits while an earlier
// result is still stalled in the output register. The next request is taken
// while the previous result waits in the output register. Writing frame_columns
// or frame_rows restarts the frame; config must be written only while idle,
// which the block itself does not enforce.
module box_blend_smoother
   import bbs_pkg::*;
#(
   parameter int MAX_COLUMNS  = 1024,
   parameter int CHANNEL_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [1:0]                     csr_index,
   input  logic [CSR_BITS-1:0]            csr_write_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [CHANNEL_BITS-1:0] req_red_in,
   input  logic signed [CHANNEL_BITS-1:0] req_green_in,
   input  logic signed [CHANNEL_BITS-1:0] req_blue_in,
   input  logic signed [CHANNEL_BITS-1:0] req_value_in,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [ROWS_BITS-1:0]           rsp_out_row,
   output logic [$clog2(MAX_COLUMNS)-1:0] rsp_out_col,
   output logic signed [CHANNEL_BITS-1:0] rsp_red_out,
   output logic signed [CHANNEL_BITS-1:0] rsp_green_out,
   output logic signed [CHANNEL_BITS-1:0] rsp_blue_out,
   output logic signed [CHANNEL_BITS-1:0] rsp_value_out,
   output logic                           rsp_frame_done
);

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   bbs_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   bbs_datapath #(
      .MAX_COLUMNS  (MAX_COLUMNS),
      .CHANNEL_BITS (CHANNEL_BITS),
      .COL_BITS     ($clog2(MAX_COLUMNS))
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_red_in       (req_red_in),
      .req_green_in     (req_green_in),
      .req_blue_in      (req_blue_in),
      .req_value_in     (req_value_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_row      (rsp_out_row),
      .rsp_out_col      (rsp_out_col),
      .rsp_red_out      (rsp_red_out),
      .rsp_green_out    (rsp_green_out),
      .rsp_blue_out     (rsp_blue_out),
      .rsp_value_out    (rsp_value_out),
      .rsp_frame_done   (rsp_frame_done)
   );

endmodule

/* hdl/bbs_controller.sv */
module bbs_controller
   import bbs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  ctrl_sts_type sts,
   output ctrl_cmd_type cmd
);

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid) state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum_en = 1'b1;
            state_in   = sts.interior ? ST_MUL : ST_IDLE;
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_ADD;
         end
         ST_ADD: begin
            cmd.add_en = 1'b1;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_en = 1'b1;
            state_in   = ST_FIN;
         end
         ST_FIN: begin
            cmd.out_load = sts.out_free;
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

/* hdl/bbs_datapath.sv */
`include "box_blend_smoother_macros.svh"

module bbs_datapath
   import bbs_pkg::*;
#(
   parameter int MAX_COLUMNS  = 1024,
   parameter int CHANNEL_BITS = 16,
   parameter int COL_BITS     = $clog2(MAX_COLUMNS)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ctrl_cmd_type                   cmd,
   output ctrl_sts_type                   sts,
   input  logic                           csr_write_enable,
   input  logic [1:0]                     csr_index,
   input  logic [CSR_BITS-1:0]            csr_write_data,
   input  logic signed [CHANNEL_BITS-1:0] req_red_in,
   input  logic signed [CHANNEL_BITS-1:0] req_green_in,
   input  logic signed [CHANNEL_BITS-1:0] req_blue_in,
   input  logic signed [CHANNEL_BITS-1:0] req_value_in,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [ROWS_BITS-1:0]           rsp_out_row,
   output logic [COL_BITS-1:0]            rsp_out_col,
   output logic signed [CHANNEL_BITS-1:0] rsp_red_out,
   output logic signed [CHANNEL_BITS-1:0] rsp_green_out,
   output logic signed [CHANNEL_BITS-1:0] rsp_blue_out,
   output logic signed [CHANNEL_BITS-1:0] rsp_value_out,
   output logic                           rsp_frame_done
);

   localparam int CB     = CHANNEL_BITS;
   localparam int PW     = NUM_CH * CB;
   localparam int CNT_W  = COL_BITS + 1;
   localparam int EXT_W  = (CNT_W > COLUMNS_BITS) ? CNT_W : COLUMNS_BITS;
   localparam int SW     = CB + 4;
   localparam int P1W    = CB + 18;
   localparam int P2W    = CB + 22;
   localparam int TW     = CB + 24;
   localparam int UW     = TW - 16;
   localparam int VW     = CB + 5;
   localparam int MW     = CB + 7;
   localparam int K      = CB + 9;
   localparam int PRW    = VW + MW;
   localparam int QW     = PRW - K;
   localparam int SQW    = QW + 1;
   localparam logic [TW-1:0]  ROUND_HALF = TW'(9 * 32768);
   localparam logic [UW-1:0]  V_OFFSET   = UW'(9) << CB;
   localparam logic [MW-1:0]  RECIP      = MW'(((64'd1 << K) + 64'd8) / 64'd9);
   localparam logic [SQW-1:0] Q_OFFSET   = SQW'(1) << CB;
   localparam logic signed [SQW-1:0] SAT_HI = SQW'((64'd1 << (CB - 1)) - 64'd1);
   localparam logic signed [SQW-1:0] SAT_LO = -SAT_HI - SQW'(1);
   localparam logic [EXT_W-1:0] MAX_COLS_EXT = EXT_W'(MAX_COLUMNS);
   localparam logic [EXT_W-1:0] MIN_DIM_EXT  = EXT_W'(3);

   // configuration registers
   logic [WEIGHT_BITS-1:0]  weight_ff;
   logic [COLUMNS_BITS-1:0] columns_ff;
   logic [ROWS_BITS-1:0]    rows_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff  <= '0;
         columns_ff <= COLUMNS_RESET;
         rows_ff    <= ROWS_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_WEIGHT:  weight_ff  <= csr_write_data[WEIGHT_BITS-1:0];
            CSR_COLUMNS: columns_ff <= csr_write_data[COLUMNS_BITS-1:0];
            CSR_ROWS:    rows_ff    <= csr_write_data[ROWS_BITS-1:0];
            default: ;
         endcase
      end
   end

   // effective geometry and weight
   logic [EXT_W-1:0]       cols_eff;
   logic [ROWS_BITS-1:0]   rows_eff;
   logic [WEIGHT_BITS-1:0] w_eff, inv_w;

   always_comb begin
      cols_eff = EXT_W'(columns_ff);
      if (cols_eff < MIN_DIM_EXT)  cols_eff = MIN_DIM_EXT;
      if (cols_eff > MAX_COLS_EXT) cols_eff = MAX_COLS_EXT;
      rows_eff = (rows_ff < ROWS_BITS'(3)) ? ROWS_BITS'(3) : rows_ff;
      w_eff    = (weight_ff > ONE_Q16) ? ONE_Q16 : weight_ff;
      inv_w    = ONE_Q16 - w_eff;
   end

   // raster position
   logic [COL_BITS-1:0]  col_ff, col_in, c_cur;
   logic [ROWS_BITS-1:0] row_ff, row_in, r_cur;
   logic                 geom_write;

   assign geom_write = csr_write_enable &&
                       (csr_index == CSR_COLUMNS || csr_index == CSR_ROWS);

   always_comb begin
      c_cur  = (EXT_W'(col_ff) >= cols_eff) ? '0 : col_ff;
      r_cur  = (row_ff >= rows_eff) ? '0 : row_ff;
      col_in = c_cur;
      row_in = r_cur;
      if (EXT_W'(c_cur) + EXT_W'(1) >= cols_eff) begin
         col_in = '0;
         if ({1'b0, r_cur} + 17'd1 >= {1'b0, rows_eff}) row_in = '0;
         else                                          row_in = r_cur + 16'd1;
      end else begin
         col_in = c_cur + COL_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || geom_write) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (cmd.accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // request capture and line store read
   logic [PW-1:0]        pix_ff, upper_rd_ff, middle_rd_ff;
   logic [COL_BITS-1:0]  pos_c_ff;
   logic [ROWS_BITS-1:0] pos_r_ff;
   logic                 interior_ff, done_ff;
   logic [PW-1:0]        upper_mem  [MAX_COLUMNS];
   logic [PW-1:0]        middle_mem [MAX_COLUMNS];

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pix_ff       <= {req_value_in, req_blue_in, req_green_in, req_red_in};
         pos_c_ff     <= c_cur;
         pos_r_ff     <= r_cur;
         interior_ff  <= (r_cur >= 16'd2) && (c_cur >= COL_BITS'(2));
         done_ff      <= (r_cur == rows_eff - 16'd1) &&
                         (EXT_W'(c_cur) == cols_eff - EXT_W'(1));
         upper_rd_ff  <= upper_mem[c_cur];
         middle_rd_ff <= middle_mem[c_cur];
      end
   end

   // line store write back
   always_ff @(posedge clock) begin
      if (cmd.sum_en) begin
         upper_mem[pos_c_ff]  <= middle_rd_ff;
         middle_mem[pos_c_ff] <= pix_ff;
      end
   end

   // window: win0 is column c-1, win1 column c-2; entry 0 is the top row
   logic [2:0][PW-1:0] win0_ff, win1_ff, col_vec;

   assign col_vec = {pix_ff, middle_rd_ff, upper_rd_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         win0_ff <= '0;
         win1_ff <= '0;
      end else if (cmd.sum_en) begin
         win1_ff <= win0_ff;
         win0_ff <= col_vec;
      end
   end

   // 3x3 sums
   logic signed [SW-1:0]  sum_w  [NUM_CH];
   logic signed [SW-1:0]  sum_ff [NUM_CH];
   logic signed [CB-1:0]  old_ff [NUM_CH];

   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         sum_w[ch] = '0;
         for (int rr = 0; rr < 3; rr++) begin
            sum_w[ch] = sum_w[ch]
                      + SW'($signed(col_vec[rr][ch*CB +: CB]))
                      + SW'($signed(win0_ff[rr][ch*CB +: CB]))
                      + SW'($signed(win1_ff[rr][ch*CB +: CB]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sum_en) begin
         for (int ch = 0; ch < NUM_CH; ch++) begin
            sum_ff[ch] <= sum_w[ch];
            old_ff[ch] <= $signed(win0_ff[1][ch*CB +: CB]);
         end
      end
   end

   // blend products
   logic signed [P1W-1:0] p1_ff [NUM_CH];
   logic signed [P2W-1:0] p2_ff [NUM_CH];

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         for (int ch = 0; ch < NUM_CH; ch++) begin
            p1_ff[ch] <= old_ff[ch] * $signed({1'b0, inv_w});
            p2_ff[ch] <= $signed({1'b0, w_eff}) * sum_ff[ch];
         end
      end
   end

   // total with rounding, scaled by 2^-16 and offset positive
   logic signed [TW-1:0] t_w [NUM_CH];
   logic [VW-1:0]        v_ff [NUM_CH];

   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         t_w[ch] = (TW'(p1_ff[ch]) <<< 3) + TW'(p1_ff[ch]) + TW'(p2_ff[ch])
                 + $signed(ROUND_HALF);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.add_en) begin
         for (int ch = 0; ch < NUM_CH; ch++) begin
            v_ff[ch] <= VW'(t_w[ch][TW-1:16] + V_OFFSET);
         end
      end
   end

   // divide by nine through the reciprocal
   logic [PRW-1:0] prod_ff [NUM_CH];

   always_ff @(posedge clock) begin
      if (cmd.div_en) begin
         for (int ch = 0; ch < NUM_CH; ch++) begin
            prod_ff[ch] <= PRW'(v_ff[ch]) * PRW'(RECIP);
         end
      end
   end

   // remove offset and saturate
   logic signed [SQW-1:0] q_w   [NUM_CH];
   logic signed [CB-1:0]  sat_w [NUM_CH];

   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         q_w[ch] = $signed({1'b0, prod_ff[ch][PRW-1:K]}) - $signed(Q_OFFSET);
         priority if (q_w[ch] > SAT_HI) sat_w[ch] = SAT_HI[CB-1:0];
         else if (q_w[ch] < SAT_LO)     sat_w[ch] = SAT_LO[CB-1:0];
         else                           sat_w[ch] = q_w[ch][CB-1:0];
      end
   end

   // output register
   logic                 rsp_valid_ff;
   logic [ROWS_BITS-1:0] out_row_ff;
   logic [COL_BITS-1:0]  out_col_ff;
   logic signed [CB-1:0] out_ch_ff [NUM_CH];
   logic                 out_done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_row_ff  <= pos_r_ff - 16'd1;
         out_col_ff  <= pos_c_ff - COL_BITS'(1);
         out_done_ff <= done_ff;
         for (int ch = 0; ch < NUM_CH; ch++) out_ch_ff[ch] <= sat_w[ch];
      end
   end

   assign sts.interior = interior_ff;
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_row    = out_row_ff;
   assign rsp_out_col    = out_col_ff;
   assign rsp_red_out    = out_ch_ff[0];
   assign rsp_green_out  = out_ch_ff[1];
   assign rsp_blue_out   = out_ch_ff[2];
   assign rsp_value_out  = out_ch_ff[3];
   assign rsp_frame_done = out_done_ff;

   // checks
   `BBS_ASSERT_SAME(a_mul_interior, clock, reset, cmd.mul_en, interior_ff)
   `BBS_ASSERT_SAME(a_load_free, clock, reset, cmd.out_load, !(rsp_valid_ff && rsp_stall))
   `BBS_ASSERT_NEXT(a_load_valid, clock, reset, cmd.out_load, rsp_valid_ff)

endmodule

/* tb/sv/box_blend_smoother_checker.sv */
module box_blend_smoother_checker
   import bbs_pkg::*;
#(
   parameter int MAX_COLUMNS  = 1024,
   parameter int CHANNEL_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [1:0]                     csr_index,
   input  logic [CSR_BITS-1:0]            csr_write_data,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic signed [CHANNEL_BITS-1:0] req_red_in,
   input  logic signed [CHANNEL_BITS-1:0] req_green_in,
   input  logic signed [CHANNEL_BITS-1:0] req_blue_in,
   input  logic signed [CHANNEL_BITS-1:0] req_value_in,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [ROWS_BITS-1:0]           rsp_out_row,
   input  logic [$clog2(MAX_COLUMNS)-1:0] rsp_out_col,
   input  logic signed [CHANNEL_BITS-1:0] rsp_red_out,
   input  logic signed [CHANNEL_BITS-1:0] rsp_green_out,
   input  logic signed [CHANNEL_BITS-1:0] rsp_blue_out,
   input  logic signed [CHANNEL_BITS-1:0] rsp_value_out,
   input  logic                           rsp_frame_done,
   output int                             errors,
   output int                             pending
);

   localparam int COL_BITS = $clog2(MAX_COLUMNS);

   typedef logic [NUM_CH-1:0][CHANNEL_BITS-1:0] pixel_type;

   typedef struct {
      logic [ROWS_BITS-1:0] row;
      logic [COL_BITS-1:0]  col;
      pixel_type            pix;
      logic                 done;
   } smoothed_type;

   smoothed_type smoothed_q[$];

   // mirror of the block's registers and window
   logic [WEIGHT_BITS-1:0]  weight;
   logic [COLUMNS_BITS-1:0] columns;
   logic [ROWS_BITS-1:0]    rows;
   pixel_type upper_store  [MAX_COLUMNS];
   pixel_type middle_store [MAX_COLUMNS];
   pixel_type win_near [3];
   pixel_type win_far  [3];
   int unsigned row_pos, col_pos;

   function automatic longint chan_val(pixel_type p, int ch);
      return longint'($signed(p[ch]));
   endfunction

   // old + w*(mean - old), rounded half up, saturated
   function automatic longint blended(longint old, longint sum, longint w);
      longint d, t, q, hi, lo;
      d  = 9 * 65536;
      hi = (longint'(1) <<< (CHANNEL_BITS - 1)) - 1;
      lo = -hi - 1;
      t  = 9 * old * (65536 - w) + w * sum + d / 2;
      if (t >= 0) q = t / d;
      else        q = -((-t + d - 1) / d);
      if (q > hi) q = hi;
      if (q < lo) q = lo;
      return q;
   endfunction

   task automatic smooth_pixel(input pixel_type px);
      int unsigned cols, nrows, c, r;
      longint w, sum;
      pixel_type top_px, mid_px;
      smoothed_type s;
      cols  = (columns < 3) ? 3 : (columns > MAX_COLUMNS ? MAX_COLUMNS : columns);
      nrows = (rows < 3) ? 3 : rows;
      w     = (weight > ONE_Q16) ? 65536 : weight;
      c = (col_pos >= cols) ? 0 : col_pos;
      r = (row_pos >= nrows) ? 0 : row_pos;
      top_px = upper_store[c];
      mid_px = middle_store[c];
      if (r >= 2 && c >= 2) begin
         s.row  = ROWS_BITS'(r - 1);
         s.col  = COL_BITS'(c - 1);
         s.done = (r == nrows - 1) && (c == cols - 1);
         for (int ch = 0; ch < NUM_CH; ch++) begin
            sum = chan_val(top_px, ch) + chan_val(mid_px, ch) + chan_val(px, ch);
            for (int k = 0; k < 3; k++)
               sum += chan_val(win_near[k], ch) + chan_val(win_far[k], ch);
            s.pix[ch] = CHANNEL_BITS'(blended(chan_val(win_near[1], ch), sum, w));
         end
         smoothed_q = {smoothed_q, s};
      end
      // shift the window and update the line stores
      win_far  = win_near;
      win_near = '{top_px, mid_px, px};
      upper_store[c]  = mid_px;
      middle_store[c] = px;
      c++;
      if (c >= cols) begin
         c = 0;
         r++;
         if (r >= nrows) r = 0;
      end
      col_pos = c;
      row_pos = r;
   endtask

   task automatic check_result();
      smoothed_type e;
      pixel_type got;
      string names [NUM_CH];
      names = '{"red_out", "green_out", "blue_out", "value_out"};
      got = {rsp_value_out, rsp_blue_out, rsp_green_out, rsp_red_out};
      if (smoothed_q.size() == 0) begin
         $error("unexpected result at row %0d col %0d", rsp_out_row, rsp_out_col);
         errors++;
         return;
      end
      e = smoothed_q.pop_front();
      if (rsp_out_row !== e.row) begin
         $error("out_row: expected %0d, got %0d", e.row, rsp_out_row);
         errors++;
      end
      if (rsp_out_col !== e.col) begin
         $error("out_col: expected %0d, got %0d", e.col, rsp_out_col);
         errors++;
      end
      for (int ch = 0; ch < NUM_CH; ch++)
         if (got[ch] !== e.pix[ch]) begin
            $error("%s: expected %0d, got %0d", names[ch],
                   $signed(e.pix[ch]), $signed(got[ch]));
            errors++;
         end
      if (rsp_frame_done !== e.done) begin
         $error("frame_done: expected %0d, got %0d", e.done, rsp_frame_done);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         errors   = 0;
         weight   = '0;
         columns  = COLUMNS_RESET;
         rows     = ROWS_RESET;
         win_near = '{default: '0};
         win_far  = '{default: '0};
         row_pos  = 0;
         col_pos  = 0;
         for (int i = 0; i < MAX_COLUMNS; i++) begin
            upper_store[i]  = '0;
            middle_store[i] = '0;
         end
         smoothed_q.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_WEIGHT: weight = csr_write_data[WEIGHT_BITS-1:0];
               CSR_COLUMNS: begin
                  columns = csr_write_data[COLUMNS_BITS-1:0];
                  row_pos = 0;
                  col_pos = 0;
               end
               CSR_ROWS: begin
                  rows    = csr_write_data[ROWS_BITS-1:0];
                  row_pos = 0;
                  col_pos = 0;
               end
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) check_result();
         if (req_valid && !req_stall)
            smooth_pixel({req_value_in, req_blue_in, req_green_in, req_red_in});
      end
      pending = smoothed_q.size();
   end

endmodule

/* tb/sv/box_blend_smoother_tb.sv */
module box_blend_smoother_tb;
   import bbs_pkg::*;

   localparam int CW        = 16;
   localparam int RUN_LIMIT = 1000000;
   localparam int RANDOM_PIXELS = 850;

   logic                 clock;
   logic                 reset;
   logic                 csr_write_enable;
   logic [1:0]           csr_index;
   logic [CSR_BITS-1:0]  csr_write_data;
   logic                 req_valid;
   logic                 req_stall;
   logic signed [CW-1:0] req_red_in, req_green_in, req_blue_in, req_value_in;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [ROWS_BITS-1:0] rsp_out_row;
   logic [9:0]           rsp_out_col;
   logic signed [CW-1:0] rsp_red_out, rsp_green_out, rsp_blue_out, rsp_value_out;
   logic                 rsp_frame_done;

   int errors, pending;
   int gap_pct, stall_pct;
   int cycle_count;
   int unsigned cols_eff, rows_eff;

   box_blend_smoother dut (.*);

   box_blend_smoother_checker checker_i (.*);

   // clock
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // receiver back-pressure
   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < stall_pct);

   task automatic csr_write(input logic [1:0] idx, input int unsigned data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data[CSR_BITS-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      if (idx == CSR_COLUMNS)
         cols_eff = (data[10:0] < 3) ? 3 : (data[10:0] > 1024 ? 1024 : data[10:0]);
      if (idx == CSR_ROWS)
         rows_eff = (data[15:0] < 3) ? 3 : data[15:0];
   endtask

   task automatic send_pixel(input logic [CW-1:0] r, g, b, v);
      bit took;
      if ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_red_in   <= r;
      req_green_in <= g;
      req_blue_in  <= b;
      req_value_in <= v;
      do begin
         @(negedge clock);
         took = !req_stall;
         @(posedge clock);
      end while (!took);
   endtask

   // wait for every expected result, then let a border pixel finish
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   function automatic logic [CW-1:0] rand_chan();
      case ($urandom_range(5))
         0: return 16'h7fff;
         1: return 16'h8000;
         default: return CW'($urandom);
      endcase
   endfunction

   task automatic send_random(input int n);
      for (int i = 0; i < n; i++)
         send_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan());
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin gap_pct = 0;  stall_pct = 0;  end
         1: begin gap_pct = 65; stall_pct = 0;  end
         2: begin gap_pct = 0;  stall_pct = 65; end
         default: begin gap_pct = 15; stall_pct = 15; end
      endcase
   endtask

   initial begin
      int sent, n, phase;
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_WEIGHT;
      csr_write_data   <= '0;
      req_valid        <= 1'b0;
      req_red_in       <= '0;
      req_green_in     <= '0;
      req_blue_in      <= '0;
      req_value_in     <= '0;
      cols_eff = 1024;
      rows_eff = 1024;
      set_idling(0);
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // weight above one, geometry below range, extreme checkerboard
      csr_write(CSR_WEIGHT, 131071);
      csr_write(CSR_COLUMNS, 0);
      csr_write(CSR_ROWS, 0);
      for (int i = 0; i < 9; i++)
         if (i % 2) send_pixel(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
         else       send_pixel(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
      drain();

      // zero weight keeps the centre; negative full scale around a high centre
      csr_write(CSR_WEIGHT, 0);
      for (int i = 0; i < 9; i++)
         if (i == 4) send_pixel(16'h7fff, 16'h7fff, 16'h0001, 16'hffff);
         else        send_pixel(16'h8000, 16'h8000, 16'hffff, 16'h0001);
      drain();

      // widest frame, column count above range clamps; first row wraps at full width
      set_idling(3);
      csr_write(CSR_WEIGHT, 65536);
      csr_write(CSR_COLUMNS, 2047);
      csr_write(CSR_ROWS, 3);
      send_random(1024 + 40);
      drain();

      // tallest frame, only a few rows of it
      csr_write(CSR_WEIGHT, 32768);
      csr_write(CSR_COLUMNS, 3);
      csr_write(CSR_ROWS, 65535);
      send_random(30);
      drain();

      // random phases; each boundary is a full drain
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_PIXELS) begin
         set_idling(phase % 4);
         if ($urandom_range(99) < 60)
            case ($urandom_range(3))
               0: csr_write(CSR_WEIGHT, $urandom_range(0, 131071));
               1: csr_write(CSR_WEIGHT, 65536);
               2: csr_write(CSR_WEIGHT, 0);
               default: csr_write(CSR_WEIGHT, $urandom_range(1, 65535));
            endcase
         if ($urandom_range(99) < 60)
            case ($urandom_range(9))
               0: csr_write(CSR_COLUMNS, $urandom_range(0, 2047));
               1: csr_write(CSR_COLUMNS, $urandom_range(0, 2));
               default: csr_write(CSR_COLUMNS, $urandom_range(3, 12));
            endcase
         if ($urandom_range(99) < 50)
            case ($urandom_range(9))
               0: csr_write(CSR_ROWS, 65535 - $urandom_range(0, 3));
               1: csr_write(CSR_ROWS, $urandom_range(0, 65535));
               default: csr_write(CSR_ROWS, $urandom_range(0, 8));
            endcase
         if ($urandom_range(99) < 25)
            n = $urandom_range(1, 40);
         else
            n = cols_eff * ((rows_eff > 8) ? 3 : rows_eff) * $urandom_range(1, 2);
         if (n > 400) n = 400;
         send_random(n);
         sent += n;
         drain();
         phase++;
      end

      drain();
      repeat (20) @(posedge clock);
      if (errors == 0 && pending == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
